>>> rtl/mpp_pkg.sv
// Package for the multichannel position PID.
// Shared types, register codes, controller states and datapath constants.
// No dependencies.
package mpp_pkg;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P      = 3'd0,
      CSR_GAIN_I      = 3'd1,
      CSR_GAIN_D      = 3'd2,
      CSR_DEAD_ZONE   = 3'd3,
      CSR_WINDUP      = 3'd4,
      CSR_DRIVE_LIMIT = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [19:0] gain_p;
      logic [19:0] gain_i;
      logic [19:0] gain_d;
      logic [15:0] dead_zone;
      logic [19:0] windup;
      logic [7:0]  drive_limit;
   } cfg_type;

   localparam logic [19:0] RST_GAIN_P      = 20'd65536;
   localparam logic [19:0] RST_GAIN_I      = 20'd0;
   localparam logic [19:0] RST_GAIN_D      = 20'd6554;
   localparam logic [15:0] RST_DEAD_ZONE   = 16'd50;
   localparam logic [19:0] RST_WINDUP      = 20'd19008;
   localparam logic [7:0]  RST_DRIVE_LIMIT = 8'd191;

   // term cap 2^40, integral magnitude cap 2^43, ms per second
   localparam logic [40:0] TERM_CAP  = 41'h100_0000_0000;
   localparam logic [43:0] INTEG_CAP = 44'h800_0000_0000;
   localparam logic [9:0]  MS_PER_S  = 10'd1000;
   // 2^36/1000 rounded up: exact quotient by 1000 for dividends below 2^26
   localparam logic [26:0] RECIP_1K  = 27'd68719477;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_ERR, OP_MUL1, OP_MUL2, OP_MUL3, OP_MUL4,
      OP_IDIV, OP_ITERM, OP_DTERM, OP_SUM, OP_FIN
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ERR, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4,
      ST_IDIV, ST_ITERM, ST_DGO, ST_DWAIT, ST_SUM, ST_FIN
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type op;
      logic      div_go;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic dt_zero;
      logic idiv_last;
      logic div_done;
      logic out_free;
   } sts_type;

   function automatic logic [40:0] cap_term(input logic [63:0] mag);
      cap_term = (mag > 64'(TERM_CAP)) ? TERM_CAP : mag[40:0];
   endfunction

endpackage

>>> rtl/mpp_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Does not import mpp_pkg and has no dependencies.
module mpp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic [63:0] quotient,
   output logic        busy,
   output logic        done
);

   logic [63:0] num_ff, num_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [32:0] trial;
   logic        take;

   always_comb begin
      trial  = {rem_ff, num_ff[63]};
      take   = (trial >= {1'b0, den_ff});
      rem_in = take ? 32'(trial - {1'b0, den_ff}) : trial[31:0];
      num_in = {num_ff[62:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = num_ff;
   assign busy     = busy_ff;
   assign done     = done_ff;

endmodule

>>> rtl/mpp_ctrl.sv
// Sequencer for the PID: steps the datapath through one item at a time.
// Depends on mpp_pkg for states, commands and status.
module mpp_ctrl
   import mpp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      cmd.div_go = 1'b0;
      req_stall  = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            cmd.op   = OP_ERR;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.op   = OP_MUL1;
            state_in = sts.skip ? ST_FIN : ST_MUL2;
         end
         ST_MUL2: begin
            cmd.op   = OP_MUL2;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.op   = OP_MUL3;
            state_in = ST_MUL4;
         end
         ST_MUL4: begin
            cmd.op   = OP_MUL4;
            state_in = ST_IDIV;
         end
         ST_IDIV: begin
            cmd.op = OP_IDIV;
            if (sts.idiv_last) begin
               state_in = ST_ITERM;
            end
         end
         ST_ITERM: begin
            cmd.op   = OP_ITERM;
            state_in = sts.dt_zero ? ST_SUM : ST_DGO;
         end
         ST_DGO: begin
            cmd.div_go = 1'b1;
            state_in   = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (sts.div_done) begin
               cmd.op   = OP_DTERM;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.op   = OP_SUM;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.op   = OP_FIN;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/mpp_dp.sv
// Datapath for the PID: per-channel state, multiplies, term caps and output beat.
// Depends on mpp_pkg; the divider sits beside it at the top level.
module mpp_dp
   import mpp_pkg::*;
#(
   parameter int CHANNELS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  cfg_type     cfg,
   input  logic [1:0]  req_motor_channel,
   input  logic [31:0] req_target_position,
   input  logic [31:0] req_measured_position,
   input  logic [31:0] req_time_ms,
   output logic [63:0] div_num,
   output logic [31:0] div_den,
   input  logic [63:0] div_quo,
   input  logic        div_done,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_drive_channel,
   output logic [8:0]  rsp_drive_value,
   output logic [31:0] rsp_position_error
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [31:0] prev_time_ff [CHANNELS];
   logic [31:0] prev_err_ff  [CHANNELS];
   logic [63:0] integ_st_ff  [CHANNELS];

   logic [1:0]  ch_ff;
   logic [31:0] tgt_ff, meas_ff, time_ff;
   logic [31:0] e_ff, emag_ff;
   logic        eneg_ff, skip_ff;
   logic [29:0] lim_ff;
   logic [31:0] dt_ff;
   logic [63:0] pprod_ff, icl_ff, integ_ff, dnum_ff, iprod_ff;
   logic [40:0] pt_ff, it_ff, dterm_ff;
   logic [32:0] demag_ff;
   logic        deneg_ff, ineg_ff;
   logic [52:0] dprod_ff;
   logic [43:0] mcap_ff;
   logic [42:0] sum_ff;
   logic [63:0] iq_ff;
   logic [9:0]  ir_ff;
   logic [1:0]  idig_ff;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_ch_ff;
   logic [8:0]  rsp_drive_ff;
   logic [31:0] rsp_err_ff;

   logic [IDX_W-1:0] idx;
   logic [32:0] diff, de;
   logic [31:0] e_in, emag_in, dt_in;
   logic        skip_in;
   logic [51:0] pt_prod;
   logic signed [63:0] integ_rd, lim_s, icl_in;
   logic [63:0] pp_s, imag, isum, isat;
   logic [42:0] s_p, s_i, s_d, smag;
   logic [26:0] q_mag;
   logic [7:0]  q_cap;
   logic [8:0]  drive_in;
   logic [25:0] iv;
   logic [51:0] iv_prod;
   logic [15:0] iq_dig;
   logic [9:0]  ir_in;

   assign idx = ch_ff[IDX_W-1:0];

   always_comb begin
      diff = {tgt_ff[31], tgt_ff} - {meas_ff[31], meas_ff};
      if (diff[32] != diff[31]) begin
         e_in = diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         e_in = diff[31:0];
      end
      emag_in = e_in[31] ? (~e_in + 32'd1) : e_in;
      skip_in = (32'(ch_ff) >= 32'(CHANNELS)) || (emag_in <= 32'(cfg.dead_zone));

      dt_in    = time_ff - prev_time_ff[idx];
      pt_prod  = emag_ff * cfg.gain_p;
      de       = {e_ff[31], e_ff} - {prev_err_ff[idx][31], prev_err_ff[idx]};
      integ_rd = $signed(integ_st_ff[idx]);
      lim_s    = $signed({34'd0, lim_ff});
      if (integ_rd >= lim_s) begin
         icl_in = lim_s;
      end else if (integ_rd <= -lim_s) begin
         icl_in = -lim_s;
      end else begin
         icl_in = integ_rd;
      end

      pp_s = eneg_ff ? (~pprod_ff + 64'd1) : pprod_ff;
      isum = icl_ff + pp_s;
      if (icl_ff[63] == pp_s[63] && isum[63] != icl_ff[63]) begin
         isat = icl_ff[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end else begin
         isat = isum;
      end
      imag = integ_ff[63] ? (~integ_ff + 64'd1) : integ_ff;

      // one base-2^16 digit of the divide by 1000 per step
      iv      = {ir_ff, iprod_ff[63:48]};
      iv_prod = iv * RECIP_1K;
      iq_dig  = iv_prod[51:36];
      ir_in   = iv[9:0] - iq_dig[9:0] * MS_PER_S;

      s_p  = eneg_ff  ? (~{2'b0, pt_ff} + 43'd1)    : {2'b0, pt_ff};
      s_i  = ineg_ff  ? (~{2'b0, it_ff} + 43'd1)    : {2'b0, it_ff};
      s_d  = deneg_ff ? (~{2'b0, dterm_ff} + 43'd1) : {2'b0, dterm_ff};

      smag  = sum_ff[42] ? (~sum_ff + 43'd1) : sum_ff;
      q_mag = smag[42:16];
      q_cap = (q_mag > 27'(cfg.drive_limit)) ? cfg.drive_limit : q_mag[7:0];
      drive_in = sum_ff[42] ? {1'b0, q_cap} : (~{1'b0, q_cap} + 9'd1);
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            ch_ff   <= req_motor_channel;
            tgt_ff  <= req_target_position;
            meas_ff <= req_measured_position;
            time_ff <= req_time_ms;
         end
         OP_ERR: begin
            e_ff    <= e_in;
            emag_ff <= emag_in;
            eneg_ff <= e_in[31];
            skip_ff <= skip_in;
            lim_ff  <= 30'({10'd0, cfg.windup} * 30'(MS_PER_S));
         end
         OP_MUL1: begin
            dt_ff    <= dt_in;
            pprod_ff <= emag_ff * dt_in;
            pt_ff    <= cap_term(64'(pt_prod));
            demag_ff <= de[32] ? (~de + 33'd1) : de;
            deneg_ff <= de[32];
            icl_ff   <= icl_in;
         end
         OP_MUL2: begin
            integ_ff <= isat;
            dprod_ff <= demag_ff * cfg.gain_d;
         end
         OP_MUL3: begin
            ineg_ff <= integ_ff[63];
            mcap_ff <= (imag > 64'(INTEG_CAP)) ? INTEG_CAP : imag[43:0];
            dnum_ff <= 64'(dprod_ff) * 64'(MS_PER_S);
         end
         OP_MUL4: begin
            iprod_ff <= mcap_ff * cfg.gain_i;
            ir_ff    <= '0;
            idig_ff  <= '0;
         end
         OP_IDIV: begin
            iprod_ff <= {iprod_ff[47:0], 16'd0};
            iq_ff    <= {iq_ff[47:0], iq_dig};
            ir_ff    <= ir_in;
            idig_ff  <= idig_ff + 2'd1;
         end
         OP_ITERM: begin
            it_ff    <= cap_term(iq_ff);
            dterm_ff <= '0;
         end
         OP_DTERM: begin
            dterm_ff <= cap_term(div_quo);
         end
         OP_SUM: begin
            sum_ff <= s_p + s_i + s_d;
         end
         OP_FIN: begin
            rsp_ch_ff    <= ch_ff;
            rsp_drive_ff <= skip_ff ? 9'd0 : drive_in;
            rsp_err_ff   <= skip_ff ? 32'd0 : e_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            prev_time_ff[i] <= '0;
            prev_err_ff[i]  <= '0;
            integ_st_ff[i]  <= '0;
         end
      end else begin
         if (cmd.op == OP_FIN) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.op == OP_FIN && !skip_ff) begin
            prev_time_ff[idx] <= time_ff;
            prev_err_ff[idx]  <= e_ff;
            integ_st_ff[idx]  <= integ_ff;
         end
      end
   end

   assign div_num = dnum_ff;
   assign div_den = dt_ff;

   assign sts.skip      = skip_ff;
   assign sts.dt_zero   = (dt_ff == 32'd0);
   assign sts.idiv_last = (idig_ff == 2'd3);
   assign sts.div_done  = div_done;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive_channel  = rsp_ch_ff;
   assign rsp_drive_value    = rsp_drive_ff;
   assign rsp_position_error = rsp_err_ff;

endmodule

>>> rtl/multichannel_position_pid.sv
// Multichannel position PID: one item at a time, one result beat per item.
// A new item is accepted only after the last one has reached the result register; a
// stall on the result holds the sequencer until that register is free. When elapsed time
// is nonzero the derivative term goes through the one-bit-per-cycle divider; when it is
// zero that term is zero, and a deadband or unused-channel item skips the arithmetic.
// Synchronous active-high reset restores register defaults and zeroes channel state.
module multichannel_position_pid
   import mpp_pkg::*;
#(
   parameter int CHANNELS = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_motor_channel,
   input  logic [31:0]           req_target_position,
   input  logic [31:0]           req_measured_position,
   input  logic [31:0]           req_time_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_drive_channel,
   output logic [8:0]            rsp_drive_value,
   output logic [31:0]           rsp_position_error,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type     cfg_ff;
   cmd_type     cmd;
   sts_type     sts;
   logic [63:0] div_num, div_quo;
   logic [31:0] div_den;
   logic        div_busy, div_done;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p      <= RST_GAIN_P;
         cfg_ff.gain_i      <= RST_GAIN_I;
         cfg_ff.gain_d      <= RST_GAIN_D;
         cfg_ff.dead_zone   <= RST_DEAD_ZONE;
         cfg_ff.windup      <= RST_WINDUP;
         cfg_ff.drive_limit <= RST_DRIVE_LIMIT;
      end else if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_GAIN_P:      cfg_ff.gain_p      <= csr_data[19:0];
            CSR_GAIN_I:      cfg_ff.gain_i      <= csr_data[19:0];
            CSR_GAIN_D:      cfg_ff.gain_d      <= csr_data[19:0];
            CSR_DEAD_ZONE:   cfg_ff.dead_zone   <= csr_data[15:0];
            CSR_WINDUP:      cfg_ff.windup      <= csr_data[19:0];
            CSR_DRIVE_LIMIT: cfg_ff.drive_limit <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   mpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mpp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_go),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (div_quo),
      .busy     (div_busy),
      .done     (div_done)
   );

   mpp_dp #(
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .cfg                   (cfg_ff),
      .req_motor_channel     (req_motor_channel),
      .req_target_position   (req_target_position),
      .req_measured_position (req_measured_position),
      .req_time_ms           (req_time_ms),
      .div_num               (div_num),
      .div_den               (div_den),
      .div_quo               (div_quo),
      .div_done              (div_done),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_drive_channel     (rsp_drive_channel),
      .rsp_drive_value       (rsp_drive_value),
      .rsp_position_error    (rsp_position_error)
   );

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while an item is in flight");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_go |-> !div_busy)
      else $error("divider restarted while busy");

   a_zero_error_zero_drive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_position_error == 32'd0) |-> rsp_drive_value == 9'd0)
      else $error("drive given for a zero error beat");
`endif

endmodule

>>> bench/testbench.sv
// Self-checking bench for the multichannel position PID with deadband and anti-windup.
// Holds a drive predictor class and the driving tasks; depends on mpp_pkg and the
// multichannel_position_pid RTL.
`timescale 1ns / 1ps

module testbench;
   import mpp_pkg::*;

   localparam int NUM_CH      = 3;
   localparam int IDLE_LIMIT  = 4000;
   localparam int SETTLE      = 250;
   localparam int RAND_ITEMS  = 145;

   typedef struct {
      bit [1:0]         ch;
      bit signed [8:0]  drive;
      bit signed [31:0] err;
   } drive_beat_type;

   class drive_predictor;
      longint unsigned gain_p, gain_i, gain_d, dead_zone, windup, drive_lim;
      bit [31:0]       last_time [NUM_CH];
      longint          last_err  [NUM_CH];
      longint          integral  [NUM_CH];
      drive_beat_type  expected_drives [$];

      function new();
         gain_p = 65536; gain_i = 0; gain_d = 6554;
         dead_zone = 50; windup = 19008; drive_lim = 191;
         foreach (last_time[i]) begin
            last_time[i] = 0; last_err[i] = 0; integral[i] = 0;
         end
      endfunction

      function void set_reg(csr_idx_type idx, bit [31:0] v);
         case (idx)
            CSR_GAIN_P:      gain_p    = v[19:0];
            CSR_GAIN_I:      gain_i    = v[19:0];
            CSR_GAIN_D:      gain_d    = v[19:0];
            CSR_DEAD_ZONE:   dead_zone = v[15:0];
            CSR_WINDUP:      windup    = v[19:0];
            CSR_DRIVE_LIMIT: drive_lim = v[7:0];
            default: ;
         endcase
      endfunction

      function longint unsigned mag(longint v);
         return (v < 0) ? longint'(0) - v : v;
      endfunction

      function longint capped(bit neg, longint unsigned m);
         longint unsigned c;
         c = (m > (64'd1 << 40)) ? (64'd1 << 40) : m;
         return neg ? -longint'(c) : longint'(c);
      endfunction

      function void note_sample(bit [1:0] ch, bit signed [31:0] tg, bit signed [31:0] ms,
                                bit [31:0] t);
         drive_beat_type  b;
         longint          e, lim, p, integ, pt, it, dterm, sum, drv, de;
         longint unsigned m;
         bit [31:0]       dt;
         b.ch = ch; b.drive = 0; b.err = 0;
         e = longint'(tg) - longint'(ms);
         if (ch < NUM_CH) begin
            if (e > 64'sh7FFF_FFFF) e = 64'sh7FFF_FFFF;
            if (e < -64'sh8000_0000) e = -64'sh8000_0000;
            if (mag(e) > dead_zone) begin
               dt = t - last_time[ch];
               integ = integral[ch];
               lim = longint'(windup) * 1000;
               if (integ >= lim) integ = lim;
               else if (integ <= -lim) integ = -lim;
               p = e * longint'({32'd0, dt});
               if (p > 0 && integ > 64'sh7FFF_FFFF_FFFF_FFFF - p)
                  integ = 64'sh7FFF_FFFF_FFFF_FFFF;
               else if (p < 0 && integ < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - p)
                  integ = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
               else integ = integ + p;
               pt = capped(e < 0, mag(e) * gain_p);
               m = mag(integ);
               if (m > (64'd1 << 43)) m = 64'd1 << 43;
               it = capped(integ < 0, (m * gain_i) / 64'd1000);
               if (dt == 0) dterm = 0;
               else begin
                  de = e - last_err[ch];
                  m = mag(de) * 64'd1000 * gain_d;
                  dterm = capped(de < 0, m / {32'd0, dt});
               end
               sum = pt + it + dterm;
               drv = -(sum / 64'sd65536);
               if (drv > longint'(drive_lim)) drv = drive_lim;
               if (drv < -longint'(drive_lim)) drv = -longint'(drive_lim);
               integral[ch] = integ;
               last_err[ch] = e;
               last_time[ch] = t;
               b.drive = drv[8:0];
               b.err = e[31:0];
            end
         end
         expected_drives.push_back(b);
      endfunction

      function string check_drive(bit [1:0] ch, bit signed [8:0] drv, bit signed [31:0] err);
         drive_beat_type b;
         if (expected_drives.size() == 0)
            return $sformatf("unexpected drive beat ch=%0d drive=%0d err=%0d", ch, drv, err);
         b = expected_drives.pop_front();
         if (b.ch != ch || b.drive != drv || b.err != err)
            return $sformatf("drive beat ch=%0d/%0d drive=%0d/%0d err=%0d/%0d (got/want)",
                             ch, b.ch, drv, b.drive, err, b.err);
         return "";
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_motor_channel = 0;
   logic [31:0] req_target_position = 0;
   logic [31:0] req_measured_position = 0;
   logic [31:0] req_time_ms = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_drive_channel;
   logic [8:0]  rsp_drive_value;
   logic [31:0] rsp_position_error;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = 0;
   logic [CSR_DATA_W-1:0] csr_data = 0;

   drive_predictor model = new();
   int          failures = 0;
   int          idle_cycles = 0;
   bit          gaps_on = 0;
   int          burst_left = 0;
   bit          hold_request = 0;
   int          stall_mode = 0;
   bit [31:0]   chan_time [4];

   multichannel_position_pid #(.CHANNELS(NUM_CH)) dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   task automatic report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      failures++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) model.set_reg(csr_idx_type'(csr_index), csr_data);
         if (req_valid && !req_stall)
            model.note_sample(req_motor_channel, req_target_position,
                              req_measured_position, req_time_ms);
         if (rsp_valid && !rsp_stall) begin
            string msg;
            msg = model.check_drive(rsp_drive_channel, rsp_drive_value, rsp_position_error);
            if (msg != "") report(msg);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // receiver stall pattern, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_request) begin
         rsp_stall = 1;
         repeat (400) @(negedge clock);
         hold_request = 0;
         rsp_stall = 0;
      end else begin
         case (stall_mode)
            0: rsp_stall = 0;
            1: rsp_stall = ($urandom_range(0, 1) == 1);
            default: rsp_stall = ($urandom_range(0, 7) < 6);
         endcase
         if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      end
   end

   task automatic write_reg(input csr_idx_type idx, input bit [31:0] v);
      @(negedge clock);
      csr_valid = 1; csr_index = idx; csr_data = v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic apply_settings(input bit [19:0] gp, gi, gd, input bit [15:0] dz,
                                 input bit [19:0] wl, input bit [7:0] dl);
      write_reg(CSR_GAIN_P, gp);
      write_reg(CSR_GAIN_I, gi);
      write_reg(CSR_GAIN_D, gd);
      write_reg(CSR_DEAD_ZONE, dz);
      write_reg(CSR_WINDUP, wl);
      write_reg(CSR_DRIVE_LIMIT, dl);
   endtask

   task automatic send_sample(input bit [1:0] ch, input bit [31:0] tg, ms, t);
      int gap;
      gap = 0;
      if (gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         burst_left = $urandom_range(1, 16);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1;
      req_motor_channel = ch; req_target_position = tg;
      req_measured_position = ms; req_time_ms = t;
      if (burst_left > 0) burst_left--;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (model.expected_drives.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic random_sample();
      bit [1:0]  ch;
      bit [31:0] ms, tg, t;
      int        err;
      ch = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, NUM_CH - 1));
      chan_time[ch] += $urandom_range(0, 30);
      t = ($urandom_range(0, 19) == 0) ? $urandom : chan_time[ch];
      ms = $urandom;
      case ($urandom_range(0, 9))
         0: tg = $urandom;
         1, 2: tg = ms + $urandom_range(0, 200000) - 100000;
         default: begin
            err = $urandom_range(0, 4000) - 2000;
            tg = ms + err;
         end
      endcase
      send_sample(ch, tg, ms, t);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;
      foreach (chan_time[i]) chan_time[i] = 100;

      // directed: reset settings
      send_sample(0, 1000, 0, 10);
      send_sample(0, 1200, 0, 10);          // zero elapsed time
      send_sample(0, 50, 0, 20);            // deadband edge
      send_sample(0, 51, 0, 30);
      send_sample(0, -50, 0, 40);
      send_sample(0, -51, 0, 50);
      send_sample(1, 32'h7FFF_FFFF, 32'h8000_0000, 60);  // error saturates high
      send_sample(1, 32'h8000_0000, 32'h7FFF_FFFF, 70);  // and low
      send_sample(1, 32'h8000_0000, 32'h0000_0000, 80);
      send_sample(1, 32'h0000_0000, 32'h8000_0001, 90);
      send_sample(2, 5000, 0, 32'hFFFF_FFF0);
      send_sample(2, 6000, 0, 32'h0000_0010);           // timestamp wrap
      send_sample(3, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);  // unused channel
      send_sample(3, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0);
      send_sample(2, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);
      send_sample(2, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
      drain();

      apply_settings(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 20'hFFFFF, 8'hFF);
      send_sample(0, 32'h7FFF_FFFF, 32'h8000_0000, 1000);
      send_sample(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      send_sample(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1000);
      send_sample(1, 65535, 0, 32'h1001);
      send_sample(1, 65536, 0, 32'h1002);
      drain();

      apply_settings(0, 0, 0, 0, 0, 0);
      send_sample(0, 1, 0, 1);
      send_sample(0, 0, 0, 2);
      send_sample(2, -1, 0, 3);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: apply_settings(65536, 0, 6554, 50, 19008, 191);
            1: apply_settings(0, 0, 0, 0, 0, 0);
            2: apply_settings(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 20'hFFFFF, 8'hFF);
            default: apply_settings($urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF),
                                    $urandom_range(0, 20'hFFFFF), $urandom_range(0, 300),
                                    $urandom_range(0, 2000), $urandom_range(0, 255));
         endcase
         gaps_on = (ph % 3 != 0);
         stall_mode = ph % 3;
         if (ph == 1 || ph == 4) hold_request = 1;
         repeat (RAND_ITEMS) random_sample();
         drain();
      end

      if (failures == 0 && model.expected_drives.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
